>>> rtl/core/sfd_pkg.sv
// Shared types, constants and helpers for the sensor frame deframer.
// Used by the front end, the job queue, the back end and the top level.
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

  localparam int MAX_PAYLOAD_BYTES_DEF = 36;

  // Framing bytes
  localparam logic [7:0] HDR_BYTE   = 8'hFF;
  localparam logic [7:0] TYPE_FIRST = 8'hA1;
  localparam logic [7:0] TYPE_LAST  = 8'hA5;

  // Frame kinds
  localparam logic [2:0] KIND_IMU      = 3'd0;
  localparam logic [2:0] KIND_DEPTH    = 3'd1;
  localparam logic [2:0] KIND_CLIMATE  = 3'd2;
  localparam logic [2:0] KIND_THRUSTER = 3'd3;
  localparam logic [2:0] KIND_SERVO    = 3'd4;

  // Payload lengths in bytes
  localparam logic [6:0] LEN_LONG  = 7'd36;
  localparam logic [6:0] LEN_MID   = 7'd16;
  localparam logic [6:0] LEN_SHORT = 7'd2;

  // Longest payload any kind carries
  localparam int LEN_MAX_KIND = 36;

  // Status codes
  localparam logic STATUS_GOOD = 1'b0;
  localparam logic STATUS_BAD  = 1'b1;

  // One finished frame handed from the front end to the back end
  typedef struct packed {
    logic [2:0] kind;
    logic       bad;
    logic       bank;
  } job_t;

  // Payload length of a kind, cut to the buffer capacity
  function automatic logic [6:0] frame_len(input logic [2:0] kind, input logic [6:0] cap);
    logic [6:0] n;
    begin
      unique case (kind)
        KIND_IMU:      n = LEN_LONG;
        KIND_DEPTH:    n = LEN_MID;
        KIND_CLIMATE:  n = LEN_MID;
        KIND_THRUSTER: n = LEN_LONG;
        default:       n = LEN_SHORT;
      endcase
      frame_len = (n > cap) ? cap : n;
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/sfd_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sfd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sfd_front.sv
// Front end: byte parser, checksum and payload packing into the frame buffer.
// Depends on sfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfd_front #(
  parameter int MAX_PAYLOAD_BYTES = sfd_pkg::MAX_PAYLOAD_BYTES_DEF,
  parameter int WAW               = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         rx_byte,
  input  wire logic               q_full,
  output logic                    q_push,
  output sfd_pkg::job_t           q_job,
  output logic                    ram_we,
  output logic      [WAW:0]       ram_waddr,
  output logic      [31:0]        ram_wdata
);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_TYPE,
    PH_LEN,
    PH_PAY,
    PH_CHK
  } phase_t;

  phase_t      phase;
  logic [2:0]  kind;
  logic [5:0]  byte_count;
  logic [7:0]  sum;
  logic        bank;
  logic [31:0] acc;
  logic [31:0] word_next;
  logic [6:0]  len;
  logic [6:0]  cnt_inc;
  logic        pay_last;
  logic        accept;

  // Hold payload and checksum bytes while both frame buffers are taken
  assign in_stall = q_full && (phase == PH_PAY || phase == PH_CHK);
  assign accept   = in_valid && !in_stall;

  assign len      = sfd_pkg::frame_len(kind, 7'(MAX_PAYLOAD_BYTES));
  assign cnt_inc  = {1'b0, byte_count} + 7'd1;
  assign pay_last = (cnt_inc >= len);

  // Place the byte in its lane; lane 0 opens a fresh word
  always_comb begin
    word_next = (byte_count[1:0] == 2'd0) ? 32'd0 : acc;
    unique case (byte_count[1:0])
      2'd0:    word_next[7:0]   = rx_byte;
      2'd1:    word_next[15:8]  = rx_byte;
      2'd2:    word_next[23:16] = rx_byte;
      default: word_next[31:24] = rx_byte;
    endcase
  end

  assign ram_we    = accept && (phase == PH_PAY) && (byte_count[1:0] == 2'd3 || pay_last);
  assign ram_waddr = {bank, byte_count[WAW+1:2]};
  assign ram_wdata = word_next;

  assign q_push     = accept && (phase == PH_CHK);
  assign q_job.kind = kind;
  assign q_job.bad  = (rx_byte != sum);
  assign q_job.bank = bank;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      kind       <= 3'd0;
      byte_count <= 6'd0;
      sum        <= 8'd0;
      bank       <= 1'b0;
    end else if (accept) begin
      unique case (phase)
        PH_TYPE: begin
          if (rx_byte == sfd_pkg::HDR_BYTE) begin
            phase <= PH_TYPE;
          end else if (rx_byte >= sfd_pkg::TYPE_FIRST && rx_byte <= sfd_pkg::TYPE_LAST) begin
            kind       <= 3'(rx_byte - sfd_pkg::TYPE_FIRST);
            sum        <= rx_byte;
            byte_count <= 6'd0;
            phase      <= PH_LEN;
          end else begin
            phase <= PH_HUNT;
          end
        end
        PH_LEN: begin
          sum        <= sum + rx_byte;
          byte_count <= 6'd0;
          phase      <= PH_PAY;
        end
        PH_PAY: begin
          sum        <= sum + rx_byte;
          byte_count <= cnt_inc[5:0];
          if (pay_last) begin
            phase <= PH_CHK;
          end
        end
        PH_CHK: begin
          phase <= PH_HUNT;
          bank  <= ~bank;
        end
        default: begin
          phase <= (rx_byte == sfd_pkg::HDR_BYTE) ? PH_TYPE : PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && phase == PH_PAY) begin
      acc <= word_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sfd_queue.sv
// Two-entry job queue between front and back end, one entry per frame buffer.
// Depends on sfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire sfd_pkg::job_t push_job,
  output logic               full,
  input  wire logic          pop,
  output logic               nonempty,
  output sfd_pkg::job_t      head
);

  sfd_pkg::job_t entry [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full     = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign head     = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_job;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sfd_back.sv
// Back end: walks a finished frame's words out of the buffer into the
// output register. Depends on sfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfd_back #(
  parameter int MAX_PAYLOAD_BYTES = sfd_pkg::MAX_PAYLOAD_BYTES_DEF,
  parameter int WAW               = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_nonempty,
  input  wire sfd_pkg::job_t q_head,
  output logic               q_pop,
  output logic               ram_re,
  output logic [WAW:0]       ram_raddr,
  input  wire logic [31:0]   ram_rdata,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [2:0]         frame_kind,
  output logic [3:0]         word_index,
  output logic [31:0]        word_value,
  output logic               status,
  output logic               last_word
);

  logic [3:0] widx;
  logic       rd_pend;
  logic [2:0] rd_kind;
  logic [3:0] rd_idx;
  logic       rd_last;
  logic       out_free;
  logic       go;
  logic       go_err;
  logic [6:0] words;
  logic [6:0] widx_inc;
  logic       at_last;

  assign words    = (sfd_pkg::frame_len(q_head.kind, 7'(MAX_PAYLOAD_BYTES)) + 7'd3) >> 2;
  assign widx_inc = {3'd0, widx} + 7'd1;
  assign at_last  = (widx_inc == words);

  // Issue only when the output register is sure to be free next cycle
  assign out_free = !out_valid || !out_stall;
  assign go       = q_nonempty && !rd_pend && out_free;
  assign go_err   = go && q_head.bad;

  assign ram_re    = go && !q_head.bad;
  assign ram_raddr = {q_head.bank, widx[WAW-1:0]};
  assign q_pop     = go_err || (ram_re && at_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      widx      <= 4'd0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_pend <= ram_re;
      if (ram_re) begin
        widx <= at_last ? 4'd0 : widx_inc[3:0];
      end
      if (rd_pend || go_err) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_kind <= q_head.kind;
      rd_idx  <= widx;
      rd_last <= at_last;
    end
    if (rd_pend) begin
      frame_kind <= rd_kind;
      word_index <= rd_idx;
      word_value <= ram_rdata;
      status     <= sfd_pkg::STATUS_GOOD;
      last_word  <= rd_last;
    end else if (go_err) begin
      frame_kind <= q_head.kind;
      word_index <= 4'd0;
      word_value <= 32'd0;
      status     <= sfd_pkg::STATUS_BAD;
      last_word  <= 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sensor_frame_deframer_sum8.sv
// Top level of the sensor frame deframer with 8-bit additive checksum.
// Depends on sfd_pkg, sfd_front, sfd_queue, sfd_back and sfd_ram.
//
// The block takes one byte per request on the input channel and hunts for a
// 0xFF header followed by a type byte 0xA1..0xA5 (kinds 0..4, payloads of
// 36, 16, 16, 36 and 2 bytes), then a length byte that only enters the
// checksum, the payload and the checksum byte. A good frame comes out as
// little-endian 32-bit words with word_index counting from 0 and last_word
// on the final one (kind 4 gives one word with its upper half zero). A bad
// checksum gives a single request with status 1, last_word 1 and zero index
// and value. Rate: the front end takes one byte per cycle; it packs payload
// bytes into words and writes them into one of two frame buffers in a shared
// RAM. Each finished frame becomes a job in a two-entry queue, one entry per
// buffer. The back end reads one word per RAM access and moves it to the
// output register, and it issues no new read while one is still pending;
// an error result goes to the output register straight from the queue head
// without a RAM read. The input stalls on payload and checksum bytes only
// while both buffers still hold frames whose last word has not been read.
`timescale 1ns / 1ps
`default_nettype none

module sensor_frame_deframer_sum8 #(
  parameter int MAX_PAYLOAD_BYTES = sfd_pkg::MAX_PAYLOAD_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Byte stream in
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  // Result words out
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       frame_kind,
  output logic [3:0]       word_index,
  output logic [31:0]      word_value,
  output logic             status,
  output logic             last_word
);

  // Longest payload actually stored, words per buffer and word address width
  localparam int LEN_CAP = (MAX_PAYLOAD_BYTES < sfd_pkg::LEN_MAX_KIND) ?
                           MAX_PAYLOAD_BYTES : sfd_pkg::LEN_MAX_KIND;
  localparam int WORDS   = (LEN_CAP + 3) / 4;
  localparam int WAW     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int RAM_DEPTH = 2 ** (WAW + 1);

  logic          q_full;
  logic          q_push;
  sfd_pkg::job_t q_job;
  logic          q_pop;
  logic          q_nonempty;
  sfd_pkg::job_t q_head;

  logic          ram_we;
  logic [WAW:0]  ram_waddr;
  logic [31:0]   ram_wdata;
  logic          ram_re;
  logic [WAW:0]  ram_raddr;
  logic [31:0]   ram_rdata;

  // Parse, check and pack bytes
  sfd_front #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES),
    .WAW              (WAW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_job),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata)
  );

  // Hand finished frames across; one entry owns one buffer
  sfd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_job(q_job),
    .full    (q_full),
    .pop     (q_pop),
    .nonempty(q_nonempty),
    .head    (q_head)
  );

  // Two frame buffers, bank bit on top of the address
  sfd_ram #(
    .WIDTH(32),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Drain words to the output register
  sfd_back #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES),
    .WAW              (WAW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_nonempty(q_nonempty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .frame_kind(frame_kind),
    .word_index(word_index),
    .word_value(word_value),
    .status    (status),
    .last_word (last_word)
  );

endmodule

`default_nettype wire

>>> rtl/core/sfd_checker.sv
// Port-level checks for the sensor frame deframer, bound to the top level.
// Depends on sfd_pkg and sensor_frame_deframer_sum8.
`timescale 1ns / 1ps
`default_nettype none

module sfd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  frame_kind,
  input wire logic [3:0]  word_index,
  input wire logic [31:0] word_value,
  input wire logic        status,
  input wire logic        last_word
);

  // A stalled request stays valid with its word and index held
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(word_value) && $stable(word_index))
    else $error("stalled result changed");

  // Error results carry no word
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> last_word && word_index == 4'd0 && word_value == 32'd0)
    else $error("malformed error result");

  // Servo frames give one 16-bit word
  a_servo_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && !status && frame_kind == sfd_pkg::KIND_SERVO |->
      word_index == 4'd0 && last_word && word_value[31:16] == 16'd0)
    else $error("bad servo word");

  // Nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");

endmodule

bind sensor_frame_deframer_sum8 sfd_checker u_sfd_checker (.*);

`default_nettype wire
